// File: hdl/sfr_pkg.sv
// Package with the item types, status codes and constants of the serial frame receiver.
`default_nettype none

package sfr_pkg;

    // Input operation codes.
    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_op;

    // Frame status codes reported with every result item.
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_IN_FRAME = 3'd1,
        ST_GOOD     = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_BAD_TAG  = 3'd4,
        ST_BAD_CMD  = 3'd5,
        ST_BAD_LEN  = 3'd6,
        ST_TIMEOUT  = 3'd7
    } t_status;

    // Receiver states: header bytes (including hunting) or payload bytes.
    typedef enum logic {
        S_HEADER  = 1'b0,
        S_PAYLOAD = 1'b1
    } t_rx_state;

    // Configuration register indexes (word addresses).
    typedef enum logic [1:0] {
        REG_DEVICE_ID    = 2'd0,
        REG_CHECK_ID     = 2'd1,
        REG_MAX_LENGTH   = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  CMD_CODE        = 8'h81;
    localparam logic [8:0]  CMD_PAIR        = 9'h0FF;
    localparam logic [7:0]  RST_DEVICE_ID   = 8'd1;
    localparam logic        RST_CHECK_ID    = 1'b1;
    localparam logic [15:0] RST_MAX_LENGTH  = 16'd1016;

    // One input item.
    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [15:0] frame_length;
    } t_out_item;

    // Classified item as it travels through the queue.
    typedef struct packed {
        logic       is_timeout;
        logic [7:0] data;
    } t_q_item;

    // Configuration seen by the frame checker.
    typedef struct packed {
        logic [7:0]  device_id;
        logic        check_device_id;
        logic [15:0] max_length;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/sfr_front.sv
// Front stage: accepts input items, classifies them and hands them to the queue.
`default_nettype none

module sfr_front
    import sfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_push,
    output t_q_item       o_push_item,
    input  wire logic     i_q_full
);

    logic    r_valid;
    t_q_item r_item;
    logic    accept;

    // The stage holds one item; it stalls only while that item cannot enter the queue.
    assign o_in_stall  = r_valid && i_q_full;
    assign o_push      = r_valid && !i_q_full;
    assign o_push_item = r_item;
    assign accept      = i_in_valid && !o_in_stall;

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Classify the accepted item: a timeout event or a received byte.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.is_timeout <= (i_in_item.op == OP_TIMEOUT);
            r_item.data       <= i_in_item.rx_byte;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sfr_queue.sv
// Short first-in first-out queue between the front and the back of the receiver.
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_item i_push_item,
    output logic         o_full,
    output logic         o_valid,
    output t_q_item      o_item,
    input  wire logic    i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    t_q_item       r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULLC);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sfr_back.sv
// Back stage: frame parser, checksum accumulator and output register.
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_q_valid,
    input  wire t_q_item i_q_item,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_item    o_out_item
);

    t_rx_state   r_state;
    t_rx_state   n_state;
    logic [15:0] r_pos;
    logic [15:0] n_pos;
    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [15:0] r_plen;
    logic [15:0] n_plen;
    logic [7:0]  r_cmd;
    logic [7:0]  n_cmd;
    logic [15:0] r_rxsum;
    logic [15:0] n_rxsum;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    logic [2:0]  pos;
    logic [7:0]  b;
    logic [15:0] sum_base;
    logic        add_hi;
    logic [15:0] word;
    logic [16:0] sum_wide;
    logic [15:0] sum_add;
    logic [15:0] pos_inc;
    logic [15:0] rxsum_full;
    logic        tag_bad;
    logic        cmd_bad;
    logic        len_bad;
    logic        payload_end;
    logic        hdr_sum_ok;
    logic        pay_sum_ok;

    // A queued item moves on whenever the output register is free or being emptied.
    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Shared decode: checksum update, field checks and frame end.
    always_comb begin
        pos         = r_pos[2:0];
        b           = i_q_item.data;
        sum_base    = (r_state == S_HEADER && pos == 3'd0) ? 16'd0 : r_sum;
        add_hi      = (r_state == S_PAYLOAD) ? r_pos[0] : pos[0];
        word        = add_hi ? {b, 8'h00} : {8'h00, b};
        sum_wide    = {1'b0, sum_base} + {1'b0, word};
        // End-around carry; the low half cannot overflow again.
        sum_add     = sum_wide[15:0] + {15'd0, sum_wide[16]};
        pos_inc     = r_pos + 16'd1;
        rxsum_full  = {b, r_rxsum[7:0]};
        tag_bad     = i_cfg.check_device_id && (b != i_cfg.device_id);
        cmd_bad     = (({1'b0, r_cmd} + {1'b0, b}) != CMD_PAIR) || (r_cmd != CMD_CODE);
        len_bad     = (r_plen > i_cfg.max_length);
        payload_end = (pos_inc == r_plen);
        hdr_sum_ok  = (~r_sum == rxsum_full);
        pay_sum_ok  = (~sum_add == r_rxsum);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (i_q_item.is_timeout) begin
            n_state = S_HEADER;
        end else if (r_state == S_PAYLOAD) begin
            if (payload_end) begin
                n_state = S_HEADER;
            end
        end else if (pos == 3'd7 && !len_bad && r_plen != 16'd0) begin
            n_state = S_PAYLOAD;
        end
    end

    // Result item and datapath updates.
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_plen     = r_plen;
        n_cmd      = r_cmd;
        n_rxsum    = r_rxsum;
        n_out_item = '{payload_valid: 1'b0, payload_byte: 8'd0,
                       status: ST_IN_FRAME, frame_length: 16'd0};
        if (i_q_item.is_timeout) begin
            if (r_state == S_PAYLOAD || r_pos != 16'd0) begin
                n_out_item.status = ST_TIMEOUT;
                n_pos = 16'd0;
                n_sum = 16'd0;
            end else begin
                n_out_item.status = ST_IDLE;
            end
        end else if (r_state == S_PAYLOAD) begin
            n_out_item.payload_valid = 1'b1;
            n_out_item.payload_byte  = b;
            n_out_item.frame_length  = r_plen;
            n_sum = sum_add;
            n_pos = pos_inc;
            if (payload_end) begin
                n_out_item.status = pay_sum_ok ? ST_GOOD : ST_BAD_SUM;
                n_pos = 16'd0;
                n_sum = 16'd0;
            end
        end else begin
            case (pos) inside
                [3'd0:3'd1]: begin
                    if (tag_bad) begin
                        n_out_item.status = ST_BAD_TAG;
                        n_pos = 16'd0;
                        n_sum = 16'd0;
                    end else begin
                        n_sum = sum_add;
                        n_pos = pos_inc;
                    end
                end
                3'd2: begin
                    n_cmd = b;
                    n_sum = sum_add;
                    n_pos = pos_inc;
                end
                3'd3: begin
                    if (cmd_bad) begin
                        n_out_item.status = ST_BAD_CMD;
                        n_pos = 16'd0;
                        n_sum = 16'd0;
                    end else begin
                        n_sum = sum_add;
                        n_pos = pos_inc;
                    end
                end
                3'd4: begin
                    n_plen = {r_plen[15:8], b};
                    n_sum  = sum_add;
                    n_pos  = pos_inc;
                end
                3'd5: begin
                    n_plen = {b, r_plen[7:0]};
                    n_sum  = sum_add;
                    n_pos  = pos_inc;
                end
                3'd6: begin
                    // The checksum field itself counts as zero in the sum.
                    n_rxsum = {r_rxsum[15:8], b};
                    n_pos   = pos_inc;
                end
                default: begin
                    // Last header byte: length check, or an empty frame ends here.
                    n_rxsum = rxsum_full;
                    n_out_item.frame_length = r_plen;
                    n_pos = 16'd0;
                    if (len_bad) begin
                        n_out_item.status = ST_BAD_LEN;
                        n_sum = 16'd0;
                    end else if (r_plen == 16'd0) begin
                        n_out_item.status = hdr_sum_ok ? ST_GOOD : ST_BAD_SUM;
                        n_sum = 16'd0;
                    end
                end
            endcase
        end
    end

    // Frame state registers, updated once per item taken from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HEADER;
            r_pos   <= 16'd0;
            r_sum   <= 16'd0;
            r_plen  <= 16'd0;
            r_cmd   <= 8'd0;
            r_rxsum <= 16'd0;
        end else if (o_pop) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_plen  <= n_plen;
            r_cmd   <= n_cmd;
            r_rxsum <= n_rxsum;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/serial_frame_receiver.sv
// Top level of the serial frame receiver: configuration registers and stage wiring.
//
//  Channel   Direction  Handshake                   Contents
//  in        input      i_in_valid / o_in_stall     t_in_item: op, rx_byte
//  out       output     o_out_valid / i_out_stall   t_out_item: payload_valid,
//                                                   payload_byte, status, frame_length
//  config    input      APB psel/penable/pwrite     device_id, check_device_id,
//                                                   max_length at 0x0, 0x4, 0x8
//
// One item per clock is sustained while the output does not stall; each item gives
// one result item. After its input item is accepted, a result item is registered in
// turn in the front register, the queue and the output register. The frame parser
// updates its state once per item taken from the queue.
// Reset is synchronous and active low; it empties the stages and starts hunting.
// Either side may stall on its own: the queue absorbs up to P_QUEUE_DEPTH items.
`default_nettype none

module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     push;
    t_q_item  push_item;
    logic     q_full;
    logic     q_valid;
    t_q_item  q_item;
    logic     pop;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id       <= RST_DEVICE_ID;
            r_cfg.check_device_id <= RST_CHECK_ID;
            r_cfg.max_length      <= RST_MAX_LENGTH;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEVICE_ID:  r_cfg.device_id       <= pwdata[7:0];
                REG_CHECK_ID:   r_cfg.check_device_id <= pwdata[0];
                REG_MAX_LENGTH: r_cfg.max_length      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        case (reg_idx)
            REG_DEVICE_ID:  prdata = {24'd0, r_cfg.device_id};
            REG_CHECK_ID:   prdata = {31'd0, r_cfg.check_device_id};
            REG_MAX_LENGTH: prdata = {16'd0, r_cfg.max_length};
            default:        prdata = '0;
        endcase
    end

    sfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_push      (push),
        .o_push_item (push_item),
        .i_q_full    (q_full)
    );

    sfr_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop       (pop)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
